// ===== hdl/c65_pkg.sv =====
// Shared types, opcode constants and small helper functions for the 6502
// subset core. No dependencies.
package c65_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_OPC, PH_OP1, PH_OP2, PH_PTRLO, PH_PTRHI, PH_DATA, PH_WRITE,
    PH_PULL1, PH_PULL2, PH_PUSHHI, PH_PUSHLO, PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY, M_REL
  } mode_t;

  typedef enum logic [4:0] {
    K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC, K_LDX, K_LDY,
    K_STX, K_STY, K_CPX, K_CPY, K_BIT, K_JMP, K_JSR, K_BR, K_NOP2, K_IMPL, K_BAD
  } kind_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  s;
    logic [7:0]  p;
    logic [15:0] pc;
    logic [7:0]  opc;
    logic [15:0] latch;
    phase_t      phase;
    logic        halt;
  } cpu_state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        wr;
    logic        fetch;
  } bus_req_t;

  typedef struct packed {
    bus_req_t    bus;
    logic        halted;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  s;
    logic [7:0]  p;
    logic [15:0] pc;
  } result_t;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] RESET_SP   = 8'hFD;
  localparam logic [7:0] RESET_P    = 8'h24;
  localparam logic [7:0] P_PUSH_SET = 8'h30;
  localparam logic [7:0] P_PULL_KEEP = 8'hEF;
  localparam logic [7:0] P_B_BIT    = 8'h10;
  localparam logic [7:0] P_U_BIT    = 8'h20;

  // status bit positions
  localparam int F_C = 0;
  localparam int F_Z = 1;
  localparam int F_I = 2;
  localparam int F_D = 3;
  localparam int F_V = 6;
  localparam int F_N = 7;

  // implied opcodes
  localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8, OP_CLI = 8'h58, OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8, OP_DEX = 8'hCA, OP_DEY = 8'h88;
  localparam logic [7:0] OP_INX = 8'hE8, OP_INY = 8'hC8, OP_NOP = 8'hEA;
  localparam logic [7:0] OP_PHA = 8'h48, OP_PHP = 8'h08, OP_PLA = 8'h68;
  localparam logic [7:0] OP_PLP = 8'h28, OP_RTS = 8'h60, OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TAY = 8'hA8, OP_TSX = 8'hBA, OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TXS = 8'h9A, OP_TYA = 8'h98;

  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[F_N] = v[7];
    r[F_Z] = (v == 8'h00);
    return r;
  endfunction

  function automatic logic is_store(kind_t k);
    return (k == K_STA) || (k == K_STX) || (k == K_STY);
  endfunction

  // Read-type execution on a fetched operand byte.
  function automatic cpu_state_t exec_read(cpu_state_t s, kind_t k, logic [7:0] v);
    cpu_state_t r;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    r = s;
    addend = (k == K_SBC) ? ~v : v;
    sum = {1'b0, s.a} + {1'b0, addend} + {8'h00, s.p[F_C]};
    cmp_reg = (k == K_CPX) ? s.x : ((k == K_CPY) ? s.y : s.a);
    diff = {1'b0, cmp_reg} - {1'b0, v};
    case (k)
      K_ORA: begin r.a = s.a | v; r.p = set_nz(s.p, r.a); end
      K_AND: begin r.a = s.a & v; r.p = set_nz(s.p, r.a); end
      K_EOR: begin r.a = s.a ^ v; r.p = set_nz(s.p, r.a); end
      K_ADC, K_SBC: begin
        r.a = sum[7:0];
        r.p = set_nz(s.p, sum[7:0]);
        r.p[F_C] = sum[8];
        r.p[F_V] = ~(s.a[7] ^ addend[7]) & (s.a[7] ^ sum[7]);
      end
      K_LDA: begin r.a = v; r.p = set_nz(s.p, v); end
      K_LDX: begin r.x = v; r.p = set_nz(s.p, v); end
      K_LDY: begin r.y = v; r.p = set_nz(s.p, v); end
      K_CMP, K_CPX, K_CPY: begin
        r.p = set_nz(s.p, diff[7:0]);
        r.p[F_C] = ~diff[8];
      end
      K_BIT: begin
        r.p[F_Z] = ((s.a & v) == 8'h00);
        r.p[F_V] = v[6];
        r.p[F_N] = v[7];
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cpu_6502_subset_core.sv =====
// Top level of the bus-driven 6502 subset core: register state, config
// register and the two-entry result buffer. Depends on c65_pkg and c65_step.

// Each input transfer is either a kick (action = 0) or the completion of the
// previously requested bus access (action = 1) with its read byte; each one
// yields exactly one output transfer describing the next access plus a
// snapshot of A, X, Y, S, P and PC. While in_stall is low, one input
// transfer is taken per clock: the whole step is a single pass of decode
// and execute logic from the register state to the result register, so the
// rate is one transfer per cycle. Results go into a two-entry buffer (output
// register plus skid), so in_stall is registered and input keeps flowing
// while one result waits. Writing start_address while the core is still
// idle (before the first kick or completion) also loads PC; later writes
// only change the register. An unsupported opcode halts the core until
// reset; halted results then repeat the PC as a plain read address.
module cpu_6502_subset_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] bus_address,
  output logic [7:0]  bus_write_data,
  output logic        bus_write,
  output logic        opcode_fetch,
  output logic        halted,
  output logic [7:0]  acc_value,
  output logic [7:0]  x_value,
  output logic [7:0]  y_value,
  output logic [7:0]  stack_value,
  output logic [7:0]  flags_value,
  output logic [15:0] pc_value
);
  import c65_pkg::*;

  cpu_state_t  state;
  cpu_state_t  state_next;
  cpu_state_t  state_upd;
  bus_req_t    bus_next;
  result_t     res_next;
  result_t     out_reg;
  result_t     skid_reg;
  logic        skid_valid;
  logic [15:0] start_address;
  logic        in_xfer;
  logic        out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  // only the skid entry being full blocks input
  assign in_stall = skid_valid;

  c65_step u_step (
    .st    (state),
    .action(action),
    .data  (read_data),
    .nst   (state_next),
    .bus   (bus_next)
  );

  assign res_next = '{bus: bus_next, halted: state_next.halt, a: state_next.a,
                      x: state_next.x, y: state_next.y, s: state_next.s,
                      p: state_next.p, pc: state_next.pc};

  // step result on a transfer, then the idle-time PC load from config
  always_comb begin
    state_upd = in_xfer ? state_next : state;
    if (cfg_write && state.phase == PH_IDLE) state_upd.pc = cfg_data;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: RESET_SP, p: RESET_P,
                 pc: 16'h0000, opc: 8'h00, latch: 16'h0000, phase: PH_IDLE,
                 halt: 1'b0};
      start_address <= 16'h0000;
    end else begin
      state <= state_upd;
      if (cfg_write) start_address <= cfg_data;
    end
  end

  // result buffer: out_reg drives the port, skid_reg catches one more
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      if (!out_valid) out_valid <= 1'b1;
      else            skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (in_xfer) out_reg <= res_next;
    end else if (in_xfer) begin
      if (!out_valid) out_reg <= res_next;
      else            skid_reg <= res_next;
    end
  end

  assign bus_address    = out_reg.bus.addr;
  assign bus_write_data = out_reg.bus.wdata;
  assign bus_write      = out_reg.bus.wr;
  assign opcode_fetch   = out_reg.bus.fetch;
  assign halted         = out_reg.halted;
  assign acc_value      = out_reg.a;
  assign x_value        = out_reg.x;
  assign y_value        = out_reg.y;
  assign stack_value    = out_reg.s;
  assign flags_value    = out_reg.p;
  assign pc_value       = out_reg.pc;

endmodule

// ===== hdl/c65_decode.sv =====
// Opcode decoder: addressing mode and operation class of one opcode.
// Depends on c65_pkg.
module c65_decode (
  input  logic [7:0]     opcode,
  output c65_pkg::mode_t mode,
  output c65_pkg::kind_t kind
);
  import c65_pkg::*;

  always_comb begin
    mode = M_IMP;
    kind = K_BAD;
    if (opcode[1:0] == 2'b01) begin
      kind = kind_t'({2'b00, opcode[7:5]});
      case (opcode[4:2])
        3'd0: mode = M_INDX;
        3'd1: mode = M_ZP;
        3'd2: mode = M_IMM;
        3'd3: mode = M_ABS;
        3'd4: mode = M_INDY;
        3'd5: mode = M_ZPX;
        3'd6: mode = M_ABSY;
        default: mode = M_ABSX;
      endcase
      if (kind == K_STA && mode == M_IMM) kind = K_NOP2;
    end else if (opcode[4:0] == 5'h10) begin
      mode = M_REL;
      kind = K_BR;
    end else begin
      unique case (opcode) inside
        8'h24: begin mode = M_ZP;   kind = K_BIT; end
        8'h2C: begin mode = M_ABS;  kind = K_BIT; end
        8'hE0: begin mode = M_IMM;  kind = K_CPX; end
        8'hE4: begin mode = M_ZP;   kind = K_CPX; end
        8'hEC: begin mode = M_ABS;  kind = K_CPX; end
        8'hC0: begin mode = M_IMM;  kind = K_CPY; end
        8'hC4: begin mode = M_ZP;   kind = K_CPY; end
        8'hCC: begin mode = M_ABS;  kind = K_CPY; end
        8'h20: begin mode = M_ABS;  kind = K_JSR; end
        8'h4C: begin mode = M_ABS;  kind = K_JMP; end
        8'hA2: begin mode = M_IMM;  kind = K_LDX; end
        8'hA6: begin mode = M_ZP;   kind = K_LDX; end
        8'hB6: begin mode = M_ZPY;  kind = K_LDX; end
        8'hAE: begin mode = M_ABS;  kind = K_LDX; end
        8'hBE: begin mode = M_ABSY; kind = K_LDX; end
        8'hA0: begin mode = M_IMM;  kind = K_LDY; end
        8'hA4: begin mode = M_ZP;   kind = K_LDY; end
        8'hB4: begin mode = M_ZPX;  kind = K_LDY; end
        8'hAC: begin mode = M_ABS;  kind = K_LDY; end
        8'hBC: begin mode = M_ABSX; kind = K_LDY; end
        8'h86: begin mode = M_ZP;   kind = K_STX; end
        8'h96: begin mode = M_ZPY;  kind = K_STX; end
        8'h8E: begin mode = M_ABS;  kind = K_STX; end
        8'h84: begin mode = M_ZP;   kind = K_STY; end
        8'h94: begin mode = M_ZPX;  kind = K_STY; end
        8'h8C: begin mode = M_ABS;  kind = K_STY; end
        OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_DEX, OP_DEY, OP_INX, OP_INY,
        OP_NOP, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_RTS, OP_SEC, OP_SED,
        OP_SEI, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA:
          kind = K_IMPL;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/c65_step.sv =====
// One bus-cycle step of the core: next register state and next bus request.
// Depends on c65_pkg and c65_decode.
module c65_step (
  input  c65_pkg::cpu_state_t st,
  input  logic                action,
  input  logic [7:0]          data,
  output c65_pkg::cpu_state_t nst,
  output c65_pkg::bus_req_t   bus
);
  import c65_pkg::*;

  mode_t cmode, dmode;
  kind_t ckind, dkind;

  c65_decode u_dec_cur  (.opcode(st.opc), .mode(cmode), .kind(ckind));
  c65_decode u_dec_data (.opcode(data),   .mode(dmode), .kind(dkind));

  always_comb begin
    logic        go_fetch;
    logic [7:0]  idx;
    logic [15:0] ea;
    logic [7:0]  zp;
    logic [7:0]  st_val;
    logic        flag;
    logic        do_at;
    logic [15:0] pcm1;

    nst = st;
    bus = '{addr: st.pc, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
    go_fetch = 1'b0;
    do_at = 1'b0;
    ea = 16'h0000;
    idx = (cmode == M_ZPX || cmode == M_ABSX) ? st.x :
          ((cmode == M_ZPY || cmode == M_ABSY) ? st.y : 8'h00);
    zp = data + idx;
    st_val = (ckind == K_STA) ? st.a : ((ckind == K_STX) ? st.x : st.y);
    case (st.opc[7:6])
      2'd0: flag = st.p[F_N];
      2'd1: flag = st.p[F_V];
      2'd2: flag = st.p[F_C];
      default: flag = st.p[F_Z];
    endcase
    pcm1 = st.pc - 16'd1;

    if (!st.halt) begin
      if (!action || st.phase == PH_IDLE) begin
        go_fetch = 1'b1;
      end else begin
        unique case (st.phase)
          PH_OPC: begin
            nst.opc = data;
            nst.pc = st.pc + 16'd1;
            if (dkind == K_BAD) begin
              nst.halt = 1'b1;
              nst.phase = PH_HALT;
            end else if (dkind == K_IMPL) begin
              go_fetch = 1'b1;
              case (data)
                OP_PHA: begin
                  bus = '{addr: {STACK_PAGE, st.s}, wdata: st.a, wr: 1'b1, fetch: 1'b0};
                  nst.s = st.s - 8'd1;
                  nst.phase = PH_WRITE;
                  go_fetch = 1'b0;
                end
                OP_PHP: begin
                  bus = '{addr: {STACK_PAGE, st.s}, wdata: st.p | P_PUSH_SET,
                          wr: 1'b1, fetch: 1'b0};
                  nst.s = st.s - 8'd1;
                  nst.phase = PH_WRITE;
                  go_fetch = 1'b0;
                end
                OP_PLA, OP_PLP, OP_RTS: begin
                  nst.s = st.s + 8'd1;
                  bus = '{addr: {STACK_PAGE, nst.s}, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
                  nst.phase = PH_PULL1;
                  go_fetch = 1'b0;
                end
                OP_CLC: nst.p[F_C] = 1'b0;
                OP_SEC: nst.p[F_C] = 1'b1;
                OP_CLD: nst.p[F_D] = 1'b0;
                OP_SED: nst.p[F_D] = 1'b1;
                OP_CLI: nst.p[F_I] = 1'b0;
                OP_SEI: nst.p[F_I] = 1'b1;
                OP_CLV: nst.p[F_V] = 1'b0;
                OP_DEX: begin nst.x = st.x - 8'd1; nst.p = set_nz(st.p, nst.x); end
                OP_DEY: begin nst.y = st.y - 8'd1; nst.p = set_nz(st.p, nst.y); end
                OP_INX: begin nst.x = st.x + 8'd1; nst.p = set_nz(st.p, nst.x); end
                OP_INY: begin nst.y = st.y + 8'd1; nst.p = set_nz(st.p, nst.y); end
                OP_TAX: begin nst.x = st.a; nst.p = set_nz(st.p, st.a); end
                OP_TAY: begin nst.y = st.a; nst.p = set_nz(st.p, st.a); end
                OP_TSX: begin nst.x = st.s; nst.p = set_nz(st.p, st.s); end
                OP_TXA: begin nst.a = st.x; nst.p = set_nz(st.p, st.x); end
                OP_TYA: begin nst.a = st.y; nst.p = set_nz(st.p, st.y); end
                OP_TXS: nst.s = st.x;
                default: ;
              endcase
            end else begin
              bus = '{addr: nst.pc, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
              nst.phase = PH_OP1;
            end
          end
          PH_OP1: begin
            nst.pc = st.pc + 16'd1;
            if (cmode == M_IMM) begin
              nst = exec_read(nst, ckind, data);
              go_fetch = 1'b1;
            end else if (cmode == M_REL) begin
              if (flag == st.opc[5]) nst.pc = nst.pc + {{8{data[7]}}, data};
              go_fetch = 1'b1;
            end else if (cmode == M_ZP || cmode == M_ZPX || cmode == M_ZPY) begin
              ea = {8'h00, zp};
              do_at = 1'b1;
            end else if (cmode == M_INDX || cmode == M_INDY) begin
              nst.latch = {8'h00, (cmode == M_INDX) ? data + st.x : data};
              bus = '{addr: nst.latch, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
              nst.phase = PH_PTRLO;
            end else begin
              nst.latch = {8'h00, data};
              bus = '{addr: nst.pc, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
              nst.phase = PH_OP2;
            end
          end
          PH_OP2: begin
            nst.pc = st.pc + 16'd1;
            if (ckind == K_JMP) begin
              nst.pc = {data, st.latch[7:0]};
              go_fetch = 1'b1;
            end else if (ckind == K_JSR) begin
              // return address minus one, high byte first
              nst.latch = {data, st.latch[7:0]};
              bus = '{addr: {STACK_PAGE, st.s}, wdata: st.pc[15:8], wr: 1'b1, fetch: 1'b0};
              nst.s = st.s - 8'd1;
              nst.phase = PH_PUSHHI;
            end else begin
              ea = {data, st.latch[7:0]} + {8'h00, idx};
              do_at = 1'b1;
            end
          end
          PH_PTRLO: begin
            nst.latch = {data, st.latch[7:0]};
            bus = '{addr: {8'h00, st.latch[7:0] + 8'd1}, wdata: 8'h00, wr: 1'b0,
                    fetch: 1'b0};
            nst.phase = PH_PTRHI;
          end
          PH_PTRHI: begin
            ea = {data, st.latch[15:8]} + ((cmode == M_INDY) ? {8'h00, st.y} : 16'h0000);
            do_at = 1'b1;
          end
          PH_DATA: begin
            nst = exec_read(st, ckind, data);
            go_fetch = 1'b1;
          end
          PH_PULL1: begin
            if (st.opc == OP_PLA) begin
              nst.a = data;
              nst.p = set_nz(st.p, data);
              go_fetch = 1'b1;
            end else if (st.opc == OP_PLP) begin
              nst.p = (data & P_PULL_KEEP) | (st.p & P_B_BIT) | P_U_BIT;
              go_fetch = 1'b1;
            end else begin
              nst.latch = {8'h00, data};
              nst.s = st.s + 8'd1;
              bus = '{addr: {STACK_PAGE, nst.s}, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
              nst.phase = PH_PULL2;
            end
          end
          PH_PULL2: begin
            nst.pc = {data, st.latch[7:0]} + 16'd1;
            go_fetch = 1'b1;
          end
          PH_PUSHHI: begin
            bus = '{addr: {STACK_PAGE, st.s}, wdata: pcm1[7:0], wr: 1'b1, fetch: 1'b0};
            nst.s = st.s - 8'd1;
            nst.phase = PH_PUSHLO;
          end
          PH_PUSHLO: begin
            nst.pc = st.latch;
            go_fetch = 1'b1;
          end
          default: go_fetch = 1'b1;
        endcase
      end
    end

    if (do_at) begin
      if (is_store(ckind)) begin
        bus = '{addr: ea, wdata: st_val, wr: 1'b1, fetch: 1'b0};
        nst.phase = PH_WRITE;
      end else begin
        bus = '{addr: ea, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
        nst.phase = PH_DATA;
      end
    end
    if (go_fetch) begin
      bus = '{addr: nst.pc, wdata: 8'h00, wr: 1'b0, fetch: 1'b1};
      nst.phase = PH_OPC;
    end
    if (nst.halt) begin
      bus = '{addr: nst.pc, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
    end
  end

endmodule

// ===== test/cpu_6502_subset_checker.sv =====
// Transfer monitor and result predictor for the 6502 subset core.
// Depends on c65_pkg; instantiated by tb beside the block.
module cpu_6502_subset_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [7:0]  read_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] bus_address,
  input  logic [7:0]  bus_write_data,
  input  logic        bus_write,
  input  logic        opcode_fetch,
  input  logic        halted,
  input  logic [7:0]  acc_value,
  input  logic [7:0]  x_value,
  input  logic [7:0]  y_value,
  input  logic [7:0]  stack_value,
  input  logic [7:0]  flags_value,
  input  logic [15:0] pc_value,
  output int          errors,
  output int          pending
);
  import c65_pkg::*;

  localparam logic [7:0] OP_BIT_ZP = 8'h24, OP_BIT_AB = 8'h2C, OP_CPX_IM = 8'hE0;
  localparam logic [7:0] OP_CPX_ZP = 8'hE4, OP_CPX_AB = 8'hEC, OP_CPY_IM = 8'hC0;
  localparam logic [7:0] OP_CPY_ZP = 8'hC4, OP_CPY_AB = 8'hCC, OP_JSR = 8'h20;
  localparam logic [7:0] OP_JMP = 8'h4C, OP_LDX_IM = 8'hA2, OP_LDX_ZP = 8'hA6;
  localparam logic [7:0] OP_LDX_ZY = 8'hB6, OP_LDX_AB = 8'hAE, OP_LDX_AY = 8'hBE;
  localparam logic [7:0] OP_LDY_IM = 8'hA0, OP_LDY_ZP = 8'hA4, OP_LDY_ZX = 8'hB4;
  localparam logic [7:0] OP_LDY_AB = 8'hAC, OP_LDY_AX = 8'hBC, OP_STX_ZP = 8'h86;
  localparam logic [7:0] OP_STX_ZY = 8'h96, OP_STX_AB = 8'h8E, OP_STY_ZP = 8'h84;
  localparam logic [7:0] OP_STY_ZX = 8'h94, OP_STY_AB = 8'h8C;

  logic [15:0] start_pc;
  logic [7:0]  a, x, y, s, p, opc;
  logic [15:0] pc, latch;
  phase_t      phase;
  logic        halt;
  bus_req_t    req;
  result_t     expq[$];

  task automatic issue(logic [15:0] ad, logic [7:0] wd, logic wr, logic fe);
    req = '{addr: ad, wdata: wd, wr: wr, fetch: fe};
  endtask

  task automatic fetch_next();
    issue(pc, 8'h00, 1'b0, 1'b1);
    phase = PH_OPC;
  endtask

  task automatic nz(logic [7:0] v);
    p[F_N] = v[7];
    p[F_Z] = (v == 8'h00);
  endtask

  task automatic push(logic [7:0] v, phase_t nph);
    issue({STACK_PAGE, s}, v, 1'b1, 1'b0);
    s = s - 8'd1;
    phase = nph;
  endtask

  task automatic pull(phase_t nph);
    s = s + 8'd1;
    issue({STACK_PAGE, s}, 8'h00, 1'b0, 1'b0);
    phase = nph;
  endtask

  function automatic void decode(logic [7:0] op, output mode_t m, output kind_t k);
    m = M_IMP;
    k = K_BAD;
    if (op[1:0] == 2'b01) begin
      k = kind_t'({2'b00, op[7:5]});
      case (op[4:2])
        3'd0: m = M_INDX;
        3'd1: m = M_ZP;
        3'd2: m = M_IMM;
        3'd3: m = M_ABS;
        3'd4: m = M_INDY;
        3'd5: m = M_ZPX;
        3'd6: m = M_ABSY;
        default: m = M_ABSX;
      endcase
      if (k == K_STA && m == M_IMM) k = K_NOP2;
    end else if (op[4:0] == 5'h10) begin
      m = M_REL;
      k = K_BR;
    end else begin
      case (op)
        OP_BIT_ZP: begin m = M_ZP;   k = K_BIT; end
        OP_BIT_AB: begin m = M_ABS;  k = K_BIT; end
        OP_CPX_IM: begin m = M_IMM;  k = K_CPX; end
        OP_CPX_ZP: begin m = M_ZP;   k = K_CPX; end
        OP_CPX_AB: begin m = M_ABS;  k = K_CPX; end
        OP_CPY_IM: begin m = M_IMM;  k = K_CPY; end
        OP_CPY_ZP: begin m = M_ZP;   k = K_CPY; end
        OP_CPY_AB: begin m = M_ABS;  k = K_CPY; end
        OP_JSR:    begin m = M_ABS;  k = K_JSR; end
        OP_JMP:    begin m = M_ABS;  k = K_JMP; end
        OP_LDX_IM: begin m = M_IMM;  k = K_LDX; end
        OP_LDX_ZP: begin m = M_ZP;   k = K_LDX; end
        OP_LDX_ZY: begin m = M_ZPY;  k = K_LDX; end
        OP_LDX_AB: begin m = M_ABS;  k = K_LDX; end
        OP_LDX_AY: begin m = M_ABSY; k = K_LDX; end
        OP_LDY_IM: begin m = M_IMM;  k = K_LDY; end
        OP_LDY_ZP: begin m = M_ZP;   k = K_LDY; end
        OP_LDY_ZX: begin m = M_ZPX;  k = K_LDY; end
        OP_LDY_AB: begin m = M_ABS;  k = K_LDY; end
        OP_LDY_AX: begin m = M_ABSX; k = K_LDY; end
        OP_STX_ZP: begin m = M_ZP;   k = K_STX; end
        OP_STX_ZY: begin m = M_ZPY;  k = K_STX; end
        OP_STX_AB: begin m = M_ABS;  k = K_STX; end
        OP_STY_ZP: begin m = M_ZP;   k = K_STY; end
        OP_STY_ZX: begin m = M_ZPX;  k = K_STY; end
        OP_STY_AB: begin m = M_ABS;  k = K_STY; end
        OP_CLC, OP_SEC, OP_CLD, OP_SED, OP_CLI, OP_SEI, OP_CLV, OP_DEX, OP_DEY,
        OP_INX, OP_INY, OP_NOP, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_RTS, OP_TAX,
        OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA: k = K_IMPL;
        default: ;
      endcase
    end
  endfunction

  function automatic logic [7:0] index_of(mode_t m);
    if (m == M_ZPX || m == M_ABSX) return x;
    if (m == M_ZPY || m == M_ABSY) return y;
    return 8'h00;
  endfunction

  task automatic at_addr(kind_t k, logic [15:0] ad);
    if (k == K_STA || k == K_STX || k == K_STY) begin
      issue(ad, (k == K_STA) ? a : ((k == K_STX) ? x : y), 1'b1, 1'b0);
      phase = PH_WRITE;
    end else begin
      issue(ad, 8'h00, 1'b0, 1'b0);
      phase = PH_DATA;
    end
  endtask

  task automatic exec_rd(kind_t k, logic [7:0] v);
    logic [7:0] addend, cr;
    logic [8:0] sum;
    addend = (k == K_SBC) ? ~v : v;
    sum = {1'b0, a} + {1'b0, addend} + {8'h00, p[F_C]};
    cr = (k == K_CPX) ? x : ((k == K_CPY) ? y : a);
    case (k)
      K_ORA: begin a = a | v; nz(a); end
      K_AND: begin a = a & v; nz(a); end
      K_EOR: begin a = a ^ v; nz(a); end
      K_ADC, K_SBC: begin
        p[F_V] = ~(a[7] ^ addend[7]) & (a[7] ^ sum[7]);
        p[F_C] = sum[8];
        a = sum[7:0];
        nz(a);
      end
      K_LDA: begin a = v; nz(v); end
      K_LDX: begin x = v; nz(v); end
      K_LDY: begin y = v; nz(v); end
      K_CMP, K_CPX, K_CPY: begin p[F_C] = (cr >= v); nz(cr - v); end
      K_BIT: begin p[F_Z] = ((a & v) == 8'h00); p[F_V] = v[6]; p[F_N] = v[7]; end
      default: ;
    endcase
  endtask

  // one instruction-sequencing step for a completion carrying byte d
  task automatic advance(logic [7:0] d);
    mode_t       m;
    kind_t       k;
    logic [15:0] ad;
    logic        taken;
    decode(opc, m, k);
    case (phase)
      PH_OPC: begin
        opc = d;
        pc = pc + 16'd1;
        decode(d, m, k);
        if (k == K_BAD) begin
          halt = 1'b1;
          phase = PH_HALT;
        end else if (k == K_IMPL) begin
          case (d)
            OP_PHA: push(a, PH_WRITE);
            OP_PHP: push(p | P_PUSH_SET, PH_WRITE);
            OP_PLA, OP_PLP, OP_RTS: pull(PH_PULL1);
            default: begin
              case (d)
                OP_CLC: p[F_C] = 1'b0;
                OP_SEC: p[F_C] = 1'b1;
                OP_CLD: p[F_D] = 1'b0;
                OP_SED: p[F_D] = 1'b1;
                OP_CLI: p[F_I] = 1'b0;
                OP_SEI: p[F_I] = 1'b1;
                OP_CLV: p[F_V] = 1'b0;
                OP_DEX: begin x = x - 8'd1; nz(x); end
                OP_DEY: begin y = y - 8'd1; nz(y); end
                OP_INX: begin x = x + 8'd1; nz(x); end
                OP_INY: begin y = y + 8'd1; nz(y); end
                OP_TAX: begin x = a; nz(x); end
                OP_TAY: begin y = a; nz(y); end
                OP_TSX: begin x = s; nz(x); end
                OP_TXA: begin a = x; nz(a); end
                OP_TYA: begin a = y; nz(a); end
                OP_TXS: s = x;
                default: ;
              endcase
              fetch_next();
            end
          endcase
        end else begin
          issue(pc, 8'h00, 1'b0, 1'b0);
          phase = PH_OP1;
        end
      end
      PH_OP1: begin
        pc = pc + 16'd1;
        if (m == M_IMM) begin
          exec_rd(k, d);
          fetch_next();
        end else if (m == M_REL) begin
          // opcode bits 7:6 pick N, V, C, Z; bit 5 is the wanted value
          case (opc[7:6])
            2'd0: taken = p[F_N];
            2'd1: taken = p[F_V];
            2'd2: taken = p[F_C];
            default: taken = p[F_Z];
          endcase
          if (taken == opc[5]) pc = pc + {{8{d[7]}}, d};
          fetch_next();
        end else if (m == M_ZP || m == M_ZPX || m == M_ZPY) begin
          at_addr(k, {8'h00, d + index_of(m)});
        end else if (m == M_INDX || m == M_INDY) begin
          latch = {8'h00, (m == M_INDX) ? d + x : d};
          issue(latch, 8'h00, 1'b0, 1'b0);
          phase = PH_PTRLO;
        end else begin
          latch = {8'h00, d};
          issue(pc, 8'h00, 1'b0, 1'b0);
          phase = PH_OP2;
        end
      end
      PH_OP2: begin
        pc = pc + 16'd1;
        ad = {d, latch[7:0]};
        if (k == K_JMP) begin
          pc = ad;
          fetch_next();
        end else if (k == K_JSR) begin
          latch = ad;
          ad = pc - 16'd1;
          push(ad[15:8], PH_PUSHHI);
        end else begin
          at_addr(k, ad + {8'h00, index_of(m)});
        end
      end
      PH_PTRLO: begin
        latch = {d, latch[7:0]};
        issue({8'h00, latch[7:0] + 8'd1}, 8'h00, 1'b0, 1'b0);
        phase = PH_PTRHI;
      end
      PH_PTRHI: begin
        ad = {d, latch[15:8]};
        if (m == M_INDY) ad = ad + {8'h00, y};
        at_addr(k, ad);
      end
      PH_DATA: begin
        exec_rd(k, d);
        fetch_next();
      end
      PH_PULL1: begin
        if (opc == OP_PLA) begin
          a = d;
          nz(d);
          fetch_next();
        end else if (opc == OP_PLP) begin
          p = (d & P_PULL_KEEP) | (p & P_B_BIT) | P_U_BIT;
          fetch_next();
        end else begin
          latch = {8'h00, d};
          pull(PH_PULL2);
        end
      end
      PH_PULL2: begin
        pc = {d, latch[7:0]} + 16'd1;
        fetch_next();
      end
      PH_PUSHHI: begin
        ad = pc - 16'd1;
        push(ad[7:0], PH_PUSHLO);
      end
      PH_PUSHLO: begin
        pc = latch;
        fetch_next();
      end
      default: fetch_next();
    endcase
  endtask

  task automatic predict_access(logic act, logic [7:0] d);
    issue(pc, 8'h00, 1'b0, 1'b0);
    if (!halt) begin
      if (!act || phase == PH_IDLE) fetch_next();
      else advance(d);
    end
    if (halt) issue(pc, 8'h00, 1'b0, 1'b0);
    expq.push_back('{bus: req, halted: halt, a: a, x: x, y: y, s: s, p: p, pc: pc});
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic check_result();
    result_t e;
    if (expq.size() == 0) begin
      report("unexpected result, bus_address", bus_address, 16'h0000);
      return;
    end
    e = expq.pop_front();
    if (bus_address !== e.bus.addr) report("bus_address", bus_address, e.bus.addr);
    if (bus_write_data !== e.bus.wdata) report("bus_write_data", bus_write_data, e.bus.wdata);
    if (bus_write !== e.bus.wr) report("bus_write", bus_write, e.bus.wr);
    if (opcode_fetch !== e.bus.fetch) report("opcode_fetch", opcode_fetch, e.bus.fetch);
    if (halted !== e.halted) report("halted", halted, e.halted);
    if (acc_value !== e.a) report("acc_value", acc_value, e.a);
    if (x_value !== e.x) report("x_value", x_value, e.x);
    if (y_value !== e.y) report("y_value", y_value, e.y);
    if (stack_value !== e.s) report("stack_value", stack_value, e.s);
    if (flags_value !== e.p) report("flags_value", flags_value, e.p);
    if (pc_value !== e.pc) report("pc_value", pc_value, e.pc);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      start_pc = 16'h0000;
      a = 8'h00; x = 8'h00; y = 8'h00;
      s = RESET_SP; p = RESET_P; pc = 16'h0000;
      opc = 8'h00; latch = 16'h0000;
      phase = PH_IDLE; halt = 1'b0;
      expq.delete();
    end else begin
      if (cfg_write) begin
        start_pc = cfg_data;
        if (phase == PH_IDLE) pc = cfg_data;
      end
      if (in_valid && !in_stall) predict_access(action, read_data);
      if (out_valid && !out_stall) check_result();
    end
    pending = expq.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the 6502 subset core testbench: clock, reset, stimulus and verdict.
// Depends on c65_pkg, cpu_6502_subset_core and cpu_6502_subset_checker.
module tb;
  import c65_pkg::*;

  localparam int LIMIT = 400000;   // cycles; slowest clean run is far below
  localparam int RAND_ITEMS = 1150;
  localparam logic [7:0] OP_ADC_IM = 8'h69, OP_SBC_IM = 8'hE9, OP_CMP_IM = 8'hC9;
  localparam logic [7:0] OP_NOP_IM = 8'h89, OP_BIT_ZP = 8'h24, OP_JSR = 8'h20;
  localparam logic [7:0] OP_BMI = 8'h30, OP_BNE = 8'hD0, OP_LDA_IX = 8'hA1;
  localparam logic [7:0] OP_STA_IY = 8'h91, OP_JMP = 8'h4C, OP_ADC_AX = 8'h7D;
  localparam logic [7:0] OP_BAD = 8'h02;
  // the remaining non-ALU, non-branch opcodes the core accepts
  localparam logic [7:0] MISC_OPS [49] = '{
    8'h24, 8'h2C, 8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4, 8'hCC, 8'h20, 8'h4C,
    8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC,
    8'h86, 8'h96, 8'h8E, 8'h84, 8'h94, 8'h8C,
    OP_CLC, OP_SEC, OP_CLD, OP_SED, OP_CLI, OP_SEI, OP_CLV, OP_DEX, OP_DEY,
    OP_INX, OP_INY, OP_NOP, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_RTS, OP_TAX,
    OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA};
  // directed instruction stream: carry/overflow arithmetic, the two-byte
  // no-op, BIT, call/return, flag push/pull, branches and pointer modes
  localparam logic [7:0] FIRST_OPS [19] = '{
    OP_SEC, OP_ADC_IM, OP_SBC_IM, OP_CMP_IM, OP_NOP_IM, OP_BIT_ZP, OP_JSR,
    OP_RTS, OP_PHP, OP_PLP, OP_PHA, OP_PLA, OP_BMI, OP_BNE, OP_LDA_IX,
    OP_STA_IY, OP_TXS, OP_ADC_AX, OP_JMP};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  read_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] bus_address, pc_value;
  logic [7:0]  bus_write_data, acc_value, x_value, y_value, stack_value, flags_value;
  logic        bus_write, opcode_fetch, halted;
  int          errors, pending;
  int          cycles = 0;
  int          tx_idle = 0, rx_idle = 0;
  int          sent = 0, replies = 0;
  logic        last_fetch = 1'b0;
  logic [7:0]  op_q[$];

  always #2 clk = ~clk;

  cpu_6502_subset_core i_dut (
    .clk, .rst, .cfg_write, .cfg_data, .in_valid, .in_stall, .action, .read_data,
    .out_valid, .out_stall, .bus_address, .bus_write_data, .bus_write,
    .opcode_fetch, .halted, .acc_value, .x_value, .y_value, .stack_value,
    .flags_value, .pc_value
  );

  cpu_6502_subset_checker i_chk (
    .clk, .rst, .cfg_write, .cfg_data, .in_valid, .in_stall, .action, .read_data,
    .out_valid, .out_stall, .bus_address, .bus_write_data, .bus_write,
    .opcode_fetch, .halted, .acc_value, .x_value, .y_value, .stack_value,
    .flags_value, .pc_value, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stall, and remember whether the last requested access
  // was an opcode fetch so the next completion can return a legal opcode
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle);
    if (!rst && out_valid && !out_stall) begin
      replies <= replies + 1;
      last_fetch <= opcode_fetch;
    end
  end

  function automatic logic [7:0] any_legal_op();
    case ($urandom_range(0, 3))
      0, 1: return {6'($urandom_range(0, 63)), 2'b01};              // ALU group
      2: return {3'($urandom_range(0, 7)), 5'h10};                  // branches
      default: return MISC_OPS[$urandom_range(0, 48)];
    endcase
  endfunction

  function automatic logic [7:0] any_operand();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one input transfer, then wait for the core's answer (lockstep bus)
  task automatic transfer(logic act, logic [7:0] d);
    while ($urandom_range(0, 99) < tx_idle) @(posedge clk);
    in_valid <= 1'b1;
    action <= act;
    read_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    action <= 1'($urandom_range(0, 1));
    read_data <= 8'($urandom_range(0, 255));
    sent++;
    while (replies < sent) @(posedge clk);
  endtask

  // completion of the last access, or a kick with chance kick_pct; legal opcode whenever a fetch was asked
  task automatic complete(int kick_pct);
    if ($urandom_range(0, 99) < kick_pct) transfer(1'b0, 8'($urandom_range(0, 255)));
    else if (last_fetch) transfer(1'b1, op_q.size() ? op_q.pop_front() : any_legal_op());
    else transfer(1'b1, any_operand());
  endtask

  task automatic set_start(logic [15:0] v);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_start(16'hFFFF);         // idle write also moves PC
    set_start(16'hFFF0);

    // directed: completion while idle acts as a kick, then the opcode list
    tx_idle = 38;
    rx_idle = 57;
    foreach (FIRST_OPS[i]) op_q.push_back(FIRST_OPS[i]);
    transfer(1'b1, 8'h00);
    while (op_q.size() > 0) complete(0);
    complete(0);
    transfer(1'b0, 8'h00);       // kick in the middle of an instruction

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 38 : ((ph == 1) ? 57 : 0);
      rx_idle = (ph == 0) ? 57 : ((ph == 1) ? 38 : 0);
      if (ph > 0) begin
        while (pending != 0) @(posedge clk);
        set_start((ph == 1) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      end
      repeat (RAND_ITEMS / 3) complete(4);
    end

    // finish with an illegal opcode, then show the core stays halted
    while (!last_fetch) complete(0);
    transfer(1'b1, OP_BAD);
    repeat (4) complete(30);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d bus transfers, random instruction streams under three", sent);
    $display("tb: stall mixes, start address writes and a final halt");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/c65_pkg.sv
hdl/c65_decode.sv
hdl/c65_step.sv
hdl/cpu_6502_subset_core.sv
test/cpu_6502_subset_checker.sv
test/tb.sv
